// ===== hdl/bril_pkg.sv =====
// bril_pkg: shared types and constants for the boot image record loader
// no dependencies; imported by bril_parse and boot_image_record_loader_core

package bril_pkg;

    // signature layout
    localparam int unsigned SignatureBytes = 7;
    localparam int unsigned SigSecondW     = 24;
    localparam logic [31:0] SigLowMask     = 32'h00FF_FFFF;

    // field widths
    localparam int unsigned ByteW  = 8;
    localparam int unsigned WordW  = 32;
    localparam int unsigned KindW  = 2;
    localparam int unsigned CfgIdxW = 2;

    // result kinds
    typedef enum logic [KindW-1:0] {
        KIND_WRITE = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_BAD   = 2'd2
    } t_kind;

    // configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        CFG_SIG_FIRST  = 2'd0,
        CFG_SIG_SECOND = 2'd1,
        CFG_RAM_BASE   = 2'd2
    } t_cfg_idx;

    // one input item
    typedef struct packed {
        logic [ByteW-1:0] data_byte;
        logic             start_of_file;
    } t_item;

    // one result, with its valid flag
    typedef struct packed {
        logic             valid;
        t_kind            kind;
        logic [WordW-1:0] address;
        logic [ByteW-1:0] write_byte;
    } t_result;

endpackage

// ===== hdl/bril_parse.sv =====
// bril_parse: image parser state and the per-item next-state and result logic
// depends on bril_pkg

module bril_parse (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_fire,
    input  bril_pkg::t_item          i_item,
    input  logic [31:0]              i_sig_first,
    input  logic [23:0]              i_sig_second,
    input  logic [31:0]              i_ram_base,
    output bril_pkg::t_result        o_result
);
    import bril_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_SIG   = 3'd1,
        PH_BASE  = 3'd2,
        PH_ISIZE = 3'd3,
        PH_RADDR = 3'd4,
        PH_RSIZE = 3'd5,
        PH_RCSUM = 3'd6,
        PH_DATA  = 3'd7
    } t_phase;

    t_phase           r_phase,  n_phase;
    logic [3:0]       r_idx,    n_idx;
    logic [WordW-1:0] r_word,   n_word;
    logic [WordW-1:0] r_base,   n_base;
    logic [WordW-1:0] r_raddr,  n_raddr;
    logic [WordW-1:0] r_left,   n_left;
    logic [WordW-1:0] r_wp,     n_wp;
    logic             r_sig_ok, n_sig_ok;
    t_result          n_result;

    // next state and result for the item at the input
    always_comb begin
        t_phase           ph;
        logic [3:0]       idx;
        logic [WordW-1:0] word;
        logic             ok;
        logic [WordW-1:0] shifted;
        logic [WordW-1:0] assembled;
        logic [WordW-1:0] left_dec;

        // start of file restarts the parser
        if (i_item.start_of_file) begin
            ph   = PH_SIG;
            idx  = '0;
            word = '0;
            ok   = 1'b1;
        end else begin
            ph   = r_phase;
            idx  = r_idx;
            word = r_word;
            ok   = r_sig_ok;
        end

        shifted   = {{(WordW-ByteW){1'b0}}, i_item.data_byte} << {idx[1:0], 3'b000};
        assembled = ((idx[1:0] == 2'd0) ? '0 : word) | shifted;
        left_dec  = r_left - 1'b1;

        n_phase  = ph;
        n_idx    = idx;
        n_word   = word;
        n_sig_ok = ok;
        n_base   = r_base;
        n_raddr  = r_raddr;
        n_left   = r_left;
        n_wp     = r_wp;
        n_result = '{valid: 1'b0, kind: KIND_WRITE, address: '0, write_byte: '0};

        case (ph)
            // signature bytes: first word, then the 24-bit second value
            PH_SIG: begin
                if (idx[3:2] == 2'd0) begin
                    n_word = assembled;
                    if (idx[1:0] == 2'd3) begin
                        if (assembled != i_sig_first) begin
                            n_sig_ok = 1'b0;
                        end
                        n_word = '0;
                    end
                end else begin
                    n_word = word | shifted;
                end
                if ({28'd0, idx} + 32'd1 >= SignatureBytes) begin
                    if ((n_word & SigLowMask) != {{(WordW-SigSecondW){1'b0}}, i_sig_second}) begin
                        n_sig_ok = 1'b0;
                    end
                    n_idx  = '0;
                    n_word = '0;
                    if (!n_sig_ok) begin
                        n_phase  = PH_IDLE;
                        n_result = '{valid: 1'b1, kind: KIND_BAD, address: '0,
                                     write_byte: '0};
                    end else begin
                        n_phase = PH_BASE;
                    end
                end else begin
                    n_idx = idx + 4'd1;
                end
            end
            // header and record words, little-endian
            PH_BASE, PH_ISIZE, PH_RADDR, PH_RSIZE, PH_RCSUM: begin
                n_word = assembled;
                if (idx[1:0] == 2'd3) begin
                    n_idx = '0;
                    case (ph)
                        PH_BASE: begin
                            n_base  = assembled;
                            n_phase = PH_ISIZE;
                        end
                        PH_ISIZE: begin
                            n_phase = PH_RADDR;
                        end
                        PH_RADDR: begin
                            n_raddr = assembled;
                            n_phase = PH_RSIZE;
                        end
                        PH_RSIZE: begin
                            n_left = assembled;
                            if (r_raddr == '0) begin
                                n_phase  = PH_IDLE;
                                n_result = '{valid: 1'b1, kind: KIND_DONE,
                                             address: assembled - r_base + i_ram_base,
                                             write_byte: '0};
                            end else begin
                                n_wp    = r_raddr - r_base + i_ram_base;
                                n_phase = PH_RCSUM;
                            end
                        end
                        default: begin
                            n_phase = (r_left == '0) ? PH_RADDR : PH_DATA;
                        end
                    endcase
                end else begin
                    n_idx = {2'b00, idx[1:0] + 2'd1};
                end
            end
            // record data: one memory write per byte
            PH_DATA: begin
                n_result = '{valid: 1'b1, kind: KIND_WRITE, address: r_wp,
                             write_byte: i_item.data_byte};
                n_wp     = r_wp + 1'b1;
                n_left   = left_dec;
                if (left_dec == '0) begin
                    n_phase = PH_RADDR;
                    n_idx   = '0;
                end
            end
            default: begin
            end
        endcase
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_idx    <= '0;
            r_word   <= '0;
            r_base   <= '0;
            r_raddr  <= '0;
            r_left   <= '0;
            r_wp     <= '0;
            r_sig_ok <= 1'b1;
        end else if (i_fire) begin
            r_phase  <= n_phase;
            r_idx    <= n_idx;
            r_word   <= n_word;
            r_base   <= n_base;
            r_raddr  <= n_raddr;
            r_left   <= n_left;
            r_wp     <= n_wp;
            r_sig_ok <= n_sig_ok;
        end
    end

    assign o_result = n_result;

endmodule

// ===== hdl/boot_image_record_loader_core.sv =====
// boot_image_record_loader_core: top level with input register, parser and result register
// depends on bril_pkg and bril_parse

// Parses a boot image streamed one byte per item and emits relocated memory
// writes, then a done item with the kernel address, or a bad-signature item.
// Throughput is one item per clock: each byte passes through an input
// register, a single pass of parser logic, and a result register. The
// input side keeps accepting while a finished result waits in the result
// register; it stalls only when both registers are full and the result is
// not being taken. Configuration is written through a plain write port and
// should be written only while no item is in flight.
module boot_image_record_loader_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration
    input  logic                        i_cfg_we,
    input  logic [bril_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [31:0]                 i_cfg_data,
    // input items
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [7:0]                  i_data_byte,
    input  logic                        i_start_of_file,
    // result items
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [1:0]                  o_kind,
    output logic [31:0]                 o_address,
    output logic [7:0]                  o_write_byte
);
    import bril_pkg::*;

    logic [31:0] r_sig_first;
    logic [23:0] r_sig_second;
    logic [31:0] r_ram_base;

    logic        r_in_valid;
    t_item       r_item;
    logic        w_adv;
    t_result     w_result;

    logic        r_out_valid;
    t_kind       r_out_kind;
    logic [31:0] r_out_address;
    logic [7:0]  r_out_write_byte;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sig_first  <= '0;
            r_sig_second <= '0;
            r_ram_base   <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_SIG_FIRST:  r_sig_first  <= i_cfg_data;
                CFG_SIG_SECOND: r_sig_second <= i_cfg_data[23:0];
                CFG_RAM_BASE:   r_ram_base   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // the held item moves on when the result register is free or draining
    assign w_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item <= '{data_byte: i_data_byte, start_of_file: i_start_of_file};
        end
    end

    // parser
    bril_parse u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (w_adv),
        .i_item       (r_item),
        .i_sig_first  (r_sig_first),
        .i_sig_second (r_sig_second),
        .i_ram_base   (r_ram_base),
        .o_result     (w_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_result.valid;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_result.valid) begin
            r_out_kind       <= w_result.kind;
            r_out_address    <= w_result.address;
            r_out_write_byte <= w_result.write_byte;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_kind       = r_out_kind;
    assign o_address    = r_out_address;
    assign o_write_byte = r_out_write_byte;

    // input side stalls only behind a blocked result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_out_valid && !i_out_ready))
        else $error("input stalled while result register free");

    // only memory writes carry a data byte
    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_out_kind != KIND_WRITE) |-> (o_write_byte == 8'd0))
        else $error("non-write item carries a data byte");

    // bad signature reports address zero
    a_bad_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_out_kind == KIND_BAD) |-> (o_address == 32'd0))
        else $error("bad-signature item with nonzero address");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// tb_top: self-checking testbench for boot_image_record_loader_core
// depends on bril_pkg and the loader rtl; streams boot images and checks every result item

module tb_top;
    import bril_pkg::*;

    // cycles with no item moving on either side before the run is called hung
    localparam int unsigned HangLimit   = 1000;
    // the result register sits behind the input register; the drain wait is margin for it
    localparam int unsigned DrainCycles = 4;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SIG, ST_BASE, ST_ISIZE, ST_RADDR, ST_RSIZE, ST_RCSUM, ST_DATA
    } t_parse_st;

    typedef struct {
        t_kind       kind;
        logic [31:0] address;
        logic [7:0]  write_byte;
    } t_load_op;

    // mirrors the parser and holds the load operations still owed by the block
    class image_load_tracker;
        logic [31:0] cfg_sig_lo;
        logic [23:0] cfg_sig_hi;
        logic [31:0] cfg_ram_base;
        t_parse_st   st;
        int unsigned field_pos;
        logic [31:0] word_acc;
        logic [31:0] img_base;
        logic [31:0] rec_addr;
        logic [31:0] remaining;
        logic [31:0] wr_addr;
        logic        sig_good;
        t_load_op    pending[$];
        int unsigned errors;

        function new();
            cfg_sig_lo   = '0;
            cfg_sig_hi   = '0;
            cfg_ram_base = '0;
            st           = ST_IDLE;
            field_pos    = 0;
            word_acc     = '0;
            img_base     = '0;
            rec_addr     = '0;
            remaining    = '0;
            wr_addr      = '0;
            sig_good     = 1'b1;
            errors       = 0;
        endfunction

        function void set_register(t_cfg_idx idx, logic [31:0] v);
            case (idx)
                CFG_SIG_FIRST:  cfg_sig_lo   = v;
                CFG_SIG_SECOND: cfg_sig_hi   = v[23:0];
                CFG_RAM_BASE:   cfg_ram_base = v;
                default: ;
            endcase
        endfunction

        function void owe(t_kind k, logic [31:0] a, logic [7:0] b);
            t_load_op op;
            op.kind       = k;
            op.address    = a;
            op.write_byte = b;
            pending.push_back(op);
        endfunction

        // little-endian word assembly, true once the fourth byte is in
        function bit gather_word(logic [7:0] b);
            int unsigned pos;
            pos = field_pos % 4;
            if (pos == 0)
                word_acc = '0;
            word_acc = word_acc | (32'(b) << (8 * pos));
            if (pos == 3) begin
                field_pos = 0;
                return 1'b1;
            end
            field_pos = pos + 1;
            return 1'b0;
        endfunction

        // one accepted input item
        function void take_byte(logic [7:0] b, logic sof);
            if (sof) begin
                st        = ST_SIG;
                field_pos = 0;
                word_acc  = '0;
                sig_good  = 1'b1;
            end
            case (st)
                ST_SIG: begin
                    if (field_pos < 4) begin
                        if (field_pos == 0)
                            word_acc = '0;
                        word_acc = word_acc | (32'(b) << (8 * field_pos));
                        if (field_pos == 3) begin
                            if (word_acc != cfg_sig_lo)
                                sig_good = 1'b0;
                            word_acc = '0;
                        end
                    end else begin
                        word_acc = word_acc | (32'(b) << (8 * (field_pos - 4)));
                    end
                    // last signature byte: check the short word and report once
                    if (field_pos + 1 >= SignatureBytes) begin
                        if ((word_acc & SigLowMask) != {8'h00, cfg_sig_hi})
                            sig_good = 1'b0;
                        field_pos = 0;
                        word_acc  = '0;
                        if (sig_good) begin
                            st = ST_BASE;
                        end else begin
                            st = ST_IDLE;
                            owe(KIND_BAD, '0, '0);
                        end
                    end else begin
                        field_pos = field_pos + 1;
                    end
                end
                ST_BASE: begin
                    if (gather_word(b)) begin
                        img_base = word_acc;
                        st       = ST_ISIZE;
                    end
                end
                ST_ISIZE: begin
                    if (gather_word(b))
                        st = ST_RADDR;
                end
                ST_RADDR: begin
                    if (gather_word(b)) begin
                        rec_addr = word_acc;
                        st       = ST_RSIZE;
                    end
                end
                ST_RSIZE: begin
                    if (gather_word(b)) begin
                        remaining = word_acc;
                        // address zero marks the end record
                        if (rec_addr == '0) begin
                            st = ST_IDLE;
                            owe(KIND_DONE, remaining - img_base + cfg_ram_base, '0);
                        end else begin
                            wr_addr = rec_addr - img_base + cfg_ram_base;
                            st      = ST_RCSUM;
                        end
                    end
                end
                ST_RCSUM: begin
                    if (gather_word(b))
                        st = (remaining == '0) ? ST_RADDR : ST_DATA;
                end
                ST_DATA: begin
                    owe(KIND_WRITE, wr_addr, b);
                    wr_addr   = wr_addr + 32'd1;
                    remaining = remaining - 32'd1;
                    if (remaining == '0) begin
                        st        = ST_RADDR;
                        field_pos = 0;
                    end
                end
                default: ;
            endcase
        endfunction

        // one accepted result item against the oldest owed operation
        function void check_output(logic [1:0] kind, logic [31:0] address, logic [7:0] wbyte);
            t_load_op want;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: kind %0d address %h byte %h",
                         $time, kind, address, wbyte);
                return;
            end
            want = pending.pop_front();
            if (kind !== want.kind) begin
                errors++;
                $display("%0t: kind mismatch: expected %0d actual %0d", $time, want.kind, kind);
            end
            if (address !== want.address) begin
                errors++;
                $display("%0t: address mismatch: expected %h actual %h",
                         $time, want.address, address);
            end
            if (wbyte !== want.write_byte) begin
                errors++;
                $display("%0t: write_byte mismatch: expected %h actual %h",
                         $time, want.write_byte, wbyte);
            end
        endfunction
    endclass

    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               cfg_we        = 1'b0;
    logic [CfgIdxW-1:0] cfg_index     = '0;
    logic [31:0]        cfg_data      = '0;
    logic               in_valid      = 1'b0;
    logic               in_ready;
    logic [7:0]         data_byte     = '0;
    logic               start_of_file = 1'b0;
    logic               out_valid;
    logic               out_ready     = 1'b0;
    logic [1:0]         res_kind;
    logic [31:0]        res_address;
    logic [7:0]         res_byte;

    image_load_tracker loader;
    t_item             image_q[$];
    bit                no_gaps     = 1'b0;
    int unsigned       bytes_sent  = 0;
    int unsigned       stall_left  = 0;
    int unsigned       hang_count  = 0;

    always #6 clk = ~clk;

    boot_image_record_loader_core u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_data_byte    (data_byte),
        .i_start_of_file(start_of_file),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_kind         (res_kind),
        .o_address      (res_address),
        .o_write_byte   (res_byte)
    );

    // idle length: mostly none, some short, a few long
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result side back-pressure
    always @(negedge clk) begin
        if (stall_left == 0 && !no_gaps && $urandom_range(0, 3) == 0)
            stall_left = pick_gap();
        if (stall_left != 0) begin
            out_ready <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // result check
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            loader.check_output(res_kind, res_address, res_byte);
    end

    // hang watchdog
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            hang_count <= 0;
        else
            hang_count <= hang_count + 1;
        if (hang_count >= HangLimit) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic void add_byte(logic [7:0] b, logic sof);
        t_item it;
        it.data_byte     = b;
        it.start_of_file = sof;
        image_q.push_back(it);
    endfunction

    function automatic void add_word(logic [31:0] w);
        for (int k = 0; k < 4; k++)
            add_byte(w[8*k +: 8], 1'b0);
    endfunction

    function automatic void add_sig(logic [31:0] w1, logic [23:0] w2);
        add_byte(w1[7:0], 1'b1);
        for (int k = 1; k < 4; k++)
            add_byte(w1[8*k +: 8], 1'b0);
        for (int k = 0; k < 3; k++)
            add_byte(w2[8*k +: 8], 1'b0);
    endfunction

    // record header, plus random payload unless it is the end record
    function automatic void add_record(logic [31:0] addr, logic [31:0] size, logic [31:0] csum);
        add_word(addr);
        add_word(size);
        add_word(csum);
        if (addr != '0) begin
            for (int unsigned k = 0; k < size; k++)
                add_byte(8'($urandom), 1'b0);
        end
    endfunction

    // one image with random content; now and then a bad signature or a cut
    function automatic void build_image();
        logic [31:0] w1;
        logic [23:0] w2;
        logic [31:0] base;
        logic [31:0] addr;
        logic [31:0] size;
        int unsigned first;
        int unsigned cut;
        first = image_q.size();
        w1    = loader.cfg_sig_lo;
        w2    = loader.cfg_sig_hi;
        if ($urandom_range(0, 7) == 0) begin
            if ($urandom_range(0, 1) == 0)
                w1 = w1 ^ (32'($urandom_range(1, 255)) << (8 * $urandom_range(0, 3)));
            else
                w2 = w2 ^ (24'($urandom_range(1, 255)) << (8 * $urandom_range(0, 2)));
        end
        add_sig(w1, w2);
        case ($urandom_range(0, 9))
            0:       base = '0;
            1:       base = '1;
            default: base = $urandom;
        endcase
        add_word(base);
        add_word($urandom);
        repeat ($urandom_range(0, 4)) begin
            case ($urandom_range(0, 3))
                0:       addr = base + $urandom_range(1, 4096);
                1:       addr = 32'hFFFF_FFFF - $urandom_range(0, 8);
                default: addr = $urandom;
            endcase
            size = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 6) : $urandom_range(7, 40);
            add_record(addr, size, $urandom);
        end
        add_record('0, $urandom, $urandom);
        // cut short: the loader runs on into the bytes that follow
        if ($urandom_range(0, 9) == 0) begin
            cut = $urandom_range(first + 1, image_q.size() - 1);
            while (image_q.size() > cut)
                void'(image_q.pop_back());
        end
        repeat ($urandom_range(0, 3))
            add_byte(8'($urandom), 1'b0);
    endfunction

    // drive one item, called and returning at a falling edge
    task automatic send_byte(t_item it);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid      = 1'b1;
        data_byte     = it.data_byte;
        start_of_file = it.start_of_file;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        loader.take_byte(it.data_byte, it.start_of_file);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic play_queue();
        foreach (image_q[k])
            send_byte(image_q[k]);
        image_q.delete();
        in_valid = 1'b0;
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [31:0] v);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = v;
        loader.set_register(idx, v);
        @(negedge clk);
    endtask

    task automatic program_regs(logic [31:0] first_w, logic [31:0] second_w,
                                logic [31:0] base_w);
        write_reg(CFG_SIG_FIRST, first_w);
        write_reg(CFG_SIG_SECOND, second_w);
        write_reg(CFG_RAM_BASE, base_w);
        cfg_we = 1'b0;
    endtask

    // all owed results in, then let the pipeline settle
    task automatic wait_drained();
        while (loader.pending.size() != 0)
            @(negedge clk);
        repeat (DrainCycles) @(negedge clk);
    endtask

    task automatic run_phase(logic [31:0] first_w, logic [31:0] second_w, logic [31:0] base_w,
                             bit steady, int unsigned n_items);
        int unsigned goal;
        wait_drained();
        program_regs(first_w, second_w, base_w);
        no_gaps = steady;
        goal    = bytes_sent + n_items;
        while (bytes_sent < goal) begin
            build_image();
            play_queue();
        end
    endtask

    initial begin
        loader = new();
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // directed images
        program_regs(32'h3030_3042, 32'h000A_4646, 32'h8000_0000);
        add_byte(8'hA5, 1'b0);                           // no start seen yet
        add_sig(32'hCFCF_CFBD, 24'h0A_4646);             // first word wrong
        add_sig(32'h3030_3042, 24'h8A_4646);             // top bit of short word wrong
        add_sig(32'h3030_3042, 24'h0A_4646);
        add_word(32'hC000_0000);
        add_word(32'hFFFF_FFFF);
        add_record(32'h4000_0010, 32'd2, 32'h0000_0000); // relocation wraps past 2^32
        add_record(32'hC000_0100, 32'd0, 32'hFFFF_FFFF); // empty record
        add_record(32'h0000_0000, 32'hC000_1000, 32'h1234_5678);
        add_byte(8'h00, 1'b0);                           // after done: ignored
        add_byte(8'hFF, 1'b0);
        play_queue();

        // random images under several register settings
        run_phase('0, '0, '0, 1'b0, 120);
        run_phase('1, '1, '1, 1'b0, 120);
        run_phase($urandom, $urandom, $urandom, 1'b1, 120);
        run_phase($urandom, $urandom, $urandom, 1'b0, 160);
        run_phase($urandom, $urandom, $urandom, 1'b0, 160);

        no_gaps = 1'b0;
        wait_drained();
        if (loader.errors == 0 && loader.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
